### rtl/gfhorner_pkg.sv
// gfhorner_pkg: constants, register indexes and field helpers for the
// GF(2^m) Horner evaluator. No dependencies; used by gf2m_poly_horner_evaluate.

package gfhorner_pkg;

	localparam int MAX_FIELD_BITS = 16;
	localparam int MIN_FIELD_BITS = 2;
	localparam int M_W            = 5;                    // field_bits register width
	localparam int POLY_W         = MAX_FIELD_BITS + 1;   // primitive_poly width
	localparam int SYM_W          = MAX_FIELD_BITS;       // symbol width
	localparam int CNT_W          = $clog2(MAX_FIELD_BITS);

	localparam logic [M_W-1:0]    FIELD_BITS_RST = M_W'(8);
	localparam logic [POLY_W-1:0] PRIM_POLY_RST  = POLY_W'(285);
	localparam logic [SYM_W-1:0]  EVAL_POINT_RST = SYM_W'(2);

	typedef enum logic [1:0] {
		REG_FIELD_BITS = 2'd0,
		REG_PRIM_POLY  = 2'd1,
		REG_EVAL_POINT = 2'd2
	} cfg_reg_t;

	typedef logic [SYM_W-1:0] sym_t;

	// clamp the configured width to the supported range
	function automatic logic [M_W-1:0] eff_width(input logic [M_W-1:0] m);
		logic [M_W-1:0] r;
		r = m;
		if (m < M_W'(MIN_FIELD_BITS)) r = M_W'(MIN_FIELD_BITS);
		if (m > M_W'(MAX_FIELD_BITS)) r = M_W'(MAX_FIELD_BITS);
		return r;
	endfunction

	function automatic sym_t width_mask(input logic [M_W-1:0] m);
		logic [SYM_W:0] t;
		t = (SYM_W+1)'(1) << m;
		t = t - (SYM_W+1)'(1);
		return t[SYM_W-1:0];
	endfunction

	// multiply by x and reduce by the polynomial, keeping m bits
	function automatic sym_t xtime(input sym_t r, input logic [POLY_W-1:0] poly,
		input logic [M_W-1:0] m, input sym_t mask);
		logic [SYM_W:0] t;
		t = {r, 1'b0};
		if (t[m]) t = t ^ poly;
		return t[SYM_W-1:0] & mask;
	endfunction

endpackage

### rtl/gf2m_poly_horner_evaluate.sv
// gf2m_poly_horner_evaluate: streaming Horner evaluation of a polynomial over GF(2^m).
// Depends on gfhorner_pkg for constants, register indexes and the xtime helper.
//
// Usage:
//   s_* channel takes one coefficient per request, highest degree first; s_tlast
//   marks the constant term. Each request updates acc = acc*point ^ coef.
//   m_* channel gives one poly_value per polynomial, after the request with
//   s_tlast; the accumulator is then cleared for the next polynomial.
//   cfg_we/cfg_index/cfg_wdata write field_bits (0), primitive_poly (1) and
//   eval_point (2); write them only while no polynomial is in flight.
// Throughput: one coefficient per cycle while s_tready is high. The product by
//   the point is a fixed GF(2) linear map, held as 16 column registers
//   (point * x^j); each request costs one AND-XOR tree from accumulator to result.
// Output: registered; the value is on m_tdata the cycle after the last coefficient.
// Reset and config: after reset, and after every config write, the column
//   table is rebuilt by a sweep (one column per cycle); s_tready is low
//   during the sweep.
// Stall: a waiting result holds in the output register; while it waits and
//   m_tready is low, s_tready is low and no coefficient is taken.

module gf2m_poly_horner_evaluate
	import gfhorner_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,    // [15:0] coefficient
	input  logic              s_tlast,    // last_coefficient
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,    // [15:0] poly_value
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [POLY_W-1:0] cfg_wdata
);

	logic [M_W-1:0]    field_bits_q;
	logic [POLY_W-1:0] prim_poly_q;
	sym_t              eval_point_q;

	sym_t              col_q [MAX_FIELD_BITS];
	sym_t              run_q;
	logic [CNT_W-1:0]  sweep_cnt_q;
	logic              sweeping_q;

	sym_t              acc_q;
	sym_t              out_q;
	logic              out_valid_q;

	logic [M_W-1:0]    m_eff;
	sym_t              mask;
	sym_t              sweep_val;
	sym_t              acc_m;
	sym_t              prod;
	sym_t              next_acc;
	logic              accept;

	assign m_eff = eff_width(field_bits_q);
	assign mask  = width_mask(m_eff);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_bits_q <= FIELD_BITS_RST;
			prim_poly_q  <= PRIM_POLY_RST;
			eval_point_q <= EVAL_POINT_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FIELD_BITS: field_bits_q <= cfg_wdata[M_W-1:0];
				REG_PRIM_POLY:  prim_poly_q  <= cfg_wdata;
				REG_EVAL_POINT: eval_point_q <= cfg_wdata[SYM_W-1:0];
				default: ;
			endcase
		end
	end

	// column sweep: shifts in point, point*x, point*x^2, ...
	assign sweep_val = (sweep_cnt_q == '0) ? (eval_point_q & mask) : run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweeping_q  <= 1'b1;
			sweep_cnt_q <= '0;
		end else if (cfg_we) begin
			sweeping_q  <= 1'b1;
			sweep_cnt_q <= '0;
		end else if (sweeping_q) begin
			sweep_cnt_q <= sweep_cnt_q + CNT_W'(1);
			if (sweep_cnt_q == CNT_W'(MAX_FIELD_BITS - 1)) sweeping_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sweeping_q && !cfg_we) begin
			for (int i = 0; i < MAX_FIELD_BITS - 1; i++) col_q[i] <= col_q[i+1];
			col_q[MAX_FIELD_BITS-1] <= sweep_val;
			run_q <= xtime(sweep_val, prim_poly_q, m_eff, mask);
		end
	end

	// datapath: acc*point as XOR of selected columns
	assign acc_m = acc_q & mask;

	always_comb begin
		prod = '0;
		for (int j = 0; j < MAX_FIELD_BITS; j++) begin
			if (acc_m[j]) prod = prod ^ col_q[j];
		end
		next_acc = (prod ^ (s_tdata & mask)) & mask;
	end

	assign s_tready = !sweeping_q && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) acc_q <= s_tlast ? '0 : next_acc;
			if (accept && s_tlast) out_valid_q <= 1'b1;
			else if (m_tready)     out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_tlast) out_q <= next_acc;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

### verif/gf2m_poly_horner_evaluate_tb.sv
`timescale 1ns / 1ps
// gf2m_poly_horner_evaluate_tb: self-checking bench for the GF(2^m) Horner evaluator.
// Drives coefficient streams under random idling and back-pressure, predicts each
// poly_value in the bench itself. Depends on gfhorner_pkg and the evaluator RTL.

module gf2m_poly_horner_evaluate_tb;
	import gfhorner_pkg::*;

	localparam int LIMIT_CYCLES = 150000;
	localparam int IDLE_PCT     = 23;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata = '0;      // [15:0] coefficient
	logic              s_tlast = 1'b0;    // last_coefficient
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [15:0]       m_tdata;           // [15:0] poly_value
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = REG_FIELD_BITS;
	logic [POLY_W-1:0] cfg_wdata = '0;

	// bench copy of the configuration and the running Horner value
	logic [M_W-1:0]    cur_width = FIELD_BITS_RST;
	logic [POLY_W-1:0] cur_poly  = PRIM_POLY_RST;
	sym_t              cur_point = EVAL_POINT_RST;
	sym_t              horner_acc = '0;
	sym_t              expected_values[$];

	bit src_gaps = 1'b1;
	bit sink_gaps = 1'b1;
	int holdoff_request = 0;
	int holdoff_left = 0;
	int fail_count = 0;
	int cycle_count = 0;
	int coef_sent = 0;

	gf2m_poly_horner_evaluate uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// shift-and-add product in GF(2^m), reduced after each shift
	function automatic sym_t gf_product(input sym_t a, input sym_t b, input int unsigned m,
		input logic [POLY_W-1:0] poly);
		logic [SYM_W:0] r;
		logic [SYM_W:0] mask;
		mask = (SYM_W+1)'((32'd1 << m) - 32'd1);
		r = '0;
		a = a & mask[SYM_W-1:0];
		b = b & mask[SYM_W-1:0];
		for (int i = m; i > 0; i--) begin
			r = r << 1;
			if (r[m]) r = r ^ poly;
			r = r & mask;
			if (b[i-1]) r = r ^ {1'b0, a};
		end
		return r[SYM_W-1:0];
	endfunction

	function automatic void horner_update(input sym_t coef, input logic last);
		int unsigned m;
		sym_t mask;
		sym_t acc;
		m = (cur_width < 2) ? 2 : ((cur_width > MAX_FIELD_BITS) ? MAX_FIELD_BITS : cur_width);
		mask = sym_t'((32'd1 << m) - 32'd1);
		acc = gf_product(horner_acc & mask, cur_point, m, cur_poly) ^ (coef & mask);
		if (last) begin
			expected_values.push_back(acc);
			horner_acc = '0;
		end else begin
			horner_acc = acc;
		end
	endfunction

	// receiver side: random stalls, plus a long hold-off when a test asks for one
	always @(posedge clk) begin
		if (holdoff_request != 0) begin
			holdoff_left = holdoff_request;
			holdoff_request = 0;
		end
		if (holdoff_left > 0) begin
			m_tready <= 1'b0;
			holdoff_left--;
		end else if (sink_gaps) begin
			m_tready <= ($urandom_range(99) >= IDLE_PCT);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		sym_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_values.size() == 0) begin
				$display("%0t: unexpected poly_value: expected none, actual %h", $time, m_tdata);
				fail_count++;
			end else begin
				want = expected_values.pop_front();
				if (m_tdata !== want) begin
					$display("%0t: poly_value mismatch: expected %h, actual %h",
						$time, want, m_tdata);
					fail_count++;
				end
			end
		end
	end

	// one coefficient request; valid stays up when the next one follows directly
	task automatic send_coefficient(input sym_t coef, input logic last);
		while (src_gaps && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= coef;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		horner_update(coef, last);
		coef_sent++;
	endtask

	task automatic send_sequence(input sym_t coefs[$]);
		foreach (coefs[i]) send_coefficient(coefs[i], i == coefs.size() - 1);
	endtask

	function automatic sym_t random_coef();
		int unsigned sel;
		sel = $urandom_range(19);
		if (sel == 0) return '0;
		if (sel == 1) return '1;
		return sym_t'($urandom);
	endfunction

	task automatic send_polynomial(input int unsigned len);
		for (int unsigned i = 0; i < len; i++) send_coefficient(random_coef(), i == len - 1);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_values.size() != 0) @(posedge clk);
		// output register latency plus margin
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [M_W-1:0] width, input logic [POLY_W-1:0] poly,
		input sym_t point);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= REG_FIELD_BITS;
		cfg_wdata <= POLY_W'(width);
		@(posedge clk);
		cfg_index <= REG_PRIM_POLY;
		cfg_wdata <= poly;
		@(posedge clk);
		cfg_index <= REG_EVAL_POINT;
		cfg_wdata <= POLY_W'(point);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_width = width;
		cur_poly  = poly;
		cur_point = point;
	endtask

	task automatic test_directed();
		// reset configuration, coefficient bits above the field are dropped
		send_sequence('{16'hFFFF});
		send_sequence('{16'h8000, 16'h00A5, 16'h0001});
		// width below the range clamps to 2
		configure(5'd0, 17'h00007, 16'h0003);
		send_sequence('{16'hFFFF, 16'h0002});
		// width above the range clamps to 16
		configure(5'd31, 17'h1100B, 16'hFFFF);
		send_sequence('{16'hFFFF, 16'hFFFF, 16'h1234});
		// full width with a non-primitive polynomial
		configure(5'd16, 17'h1FFFF, 16'h8001);
		send_sequence('{16'hFFFF, 16'h0000, 16'h8000});
		configure(5'd1, 17'h1FFFF, 16'hFFFF);
		send_sequence('{16'h0003, 16'h0001});
		// point zero leaves the constant term, point one the xor of all terms
		configure(5'd8, 17'd285, 16'h0000);
		send_sequence('{16'h0011, 16'h0022, 16'h0033});
		configure(5'd8, 17'd285, 16'h0001);
		send_sequence('{16'h0011, 16'h0022, 16'h0033});
		// polynomial bits above the field width are ignored
		configure(5'd8, 17'h1FF1D, 16'h00E5);
		send_sequence('{16'h00AB, 16'h00CD});
	endtask

	task automatic test_random_phases(input int phases, input int items_per_phase);
		logic [M_W-1:0] w;
		logic [POLY_W-1:0] p;
		sym_t pt;
		int unsigned m;
		int start;
		for (int ph = 0; ph < phases; ph++) begin
			w = ($urandom_range(3) == 0) ? M_W'($urandom_range(31)) : M_W'($urandom_range(16, 2));
			m = (w < 2) ? 2 : ((w > MAX_FIELD_BITS) ? MAX_FIELD_BITS : w);
			if ($urandom_range(1) == 0)
				p = POLY_W'($urandom);
			else
				p = POLY_W'((32'd1 << m) | ($urandom & ((32'd1 << m) - 1)) | 32'd1);
			case ($urandom_range(5))
				0: pt = '0;
				1: pt = 16'h0001;
				2: pt = '1;
				default: pt = sym_t'($urandom);
			endcase
			configure(w, p, pt);
			start = coef_sent;
			while (coef_sent - start < items_per_phase)
				send_polynomial(($urandom_range(19) == 0) ? $urandom_range(40, 11)
					: $urandom_range(10, 1));
		end
	endtask

	// long receiver hold-off while short polynomials keep coming
	task automatic test_backpressure();
		configure(5'd8, 17'd285, 16'h0053);
		src_gaps = 1'b0;
		holdoff_request = 300;
		for (int i = 0; i < 20; i++) send_polynomial($urandom_range(3, 1));
		src_gaps = 1'b1;
	endtask

	task automatic test_no_idle();
		int start;
		configure(5'd12, 17'h01053, sym_t'($urandom));
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		start = coef_sent;
		while (coef_sent - start < 80) send_polynomial($urandom_range(8, 1));
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random_phases(10, 150);
		test_no_idle();
		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
